// File: design/fsc_pkg.sv
// Shared types and constants of the frustum sphere cull unit.
package fsc_pkg;

   localparam int PLANE_COUNT = 6;
   localparam int COMP_COUNT = 4;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_DERIVE = 2'd1,
      OP_TEST = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_SQ,
      ST_SQRT,
      ST_DIV,
      ST_DIV_WAIT,
      ST_TEST,
      ST_TEST_CHK,
      ST_RESP
   } state_type;

endpackage

// File: design/fsc_div.sv
// Restoring bit-serial divider for plane normalization, one quotient bit a cycle.
module fsc_div #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] numer,
   input  logic [WORD_BITS-1:0] denom,
   output logic                 busy,
   output logic [WORD_BITS-1:0] quot
);
   localparam int NB = WORD_BITS + FRAC_BITS;
   localparam int CB = $clog2(NB + 1);

   logic          busy_ff, busy_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic [NB-1:0] num_ff, num_in;
   logic [NB-1:0] q_ff, q_in;
   logic [WORD_BITS:0] rem_ff, rem_in;
   logic [WORD_BITS:0] shifted;

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      num_in = num_ff;
      q_in = q_ff;
      rem_in = rem_ff;
      shifted = {rem_ff[WORD_BITS-1:0], num_ff[NB-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CB'(NB);
         num_in = {numer, {FRAC_BITS{1'b0}}};
         q_in = '0;
         rem_in = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[NB-2:0], 1'b0};
         if (shifted >= {1'b0, denom}) begin
            rem_in = shifted - {1'b0, denom};
            q_in = {q_ff[NB-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            q_in = {q_ff[NB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CB'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      q_ff <= q_in;
      rem_ff <= rem_in;
   end

   assign busy = busy_ff;
   // Saturate the magnitude to one past the largest word value.
   always_comb begin
      if (q_ff[NB-1:WORD_BITS-1] != '0) quot = {1'b1, {(WORD_BITS-1){1'b0}}};
      else quot = q_ff[WORD_BITS-1:0];
   end
endmodule

// File: design/frustum_sphere_cull_unit.sv
// Top level of the frustum sphere cull unit: sequencer, stores and shared multiply-accumulate.
// A load or an unused op is done on acceptance. A sphere test steps through six planes of
// three products and a check each, then holds its result word until taken; ready stays low
// meanwhile, so a new word waits until the test is through. A derive is paced by the
// bit-serial square root and the bit-serial divider; ready stays low meanwhile as well.
// Synchronous active-high reset clears the control state, the matrix and the planes.
module frustum_sphere_cull_unit #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: op[1:0], elem_index[5:2], elem_value[37:6], center_x[69:38],
   // center_y[101:70], center_z[133:102], sphere_radius[164:134], zero pad.
   input  logic [167:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: inside_res[0], zero pad.
   output logic [7:0]  rsp_tdata
);
   localparam int AW = 2 * WORD_BITS + 4;
   localparam int LW = $clog2(WORD_BITS + 1);
   localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   fsc_pkg::state_type state_ff, state_in;

   logic signed [WORD_BITS-1:0] mat_ff [16];
   logic signed [WORD_BITS-1:0] pl_ff [24];
   logic signed [WORD_BITS-1:0] cen_ff [3];
   logic [WORD_BITS-1:0] rad_ff;
   logic [2:0] plane_ff;
   logic [1:0] comp_ff;
   logic signed [AW-1:0] acc_ff;
   logic inside_ff;
   logic [WORD_BITS-1:0] root_ff;
   logic [LW-1:0] bit_ff;
   logic div_start;
   logic div_busy;
   logic [WORD_BITS-1:0] div_quot;

   logic [1:0] in_op;
   logic [3:0] in_idx;
   logic signed [31:0] in_val, in_cx, in_cy, in_cz;
   logic [30:0] in_rad;
   assign in_op = req_tdata[1:0];
   assign in_idx = req_tdata[5:2];
   assign in_val = req_tdata[37:6];
   assign in_cx = req_tdata[69:38];
   assign in_cy = req_tdata[101:70];
   assign in_cz = req_tdata[133:102];
   assign in_rad = req_tdata[164:134];

   function automatic logic signed [WORD_BITS-1:0] sat_w(input logic signed [AW-1:0] v);
      if (v > AW'(WMAX)) return WMAX;
      if (v < AW'(WMIN)) return WMIN;
      return v[WORD_BITS-1:0];
   endfunction

   // Shared multiplier: operands picked by the sequencer. One extra operand bit keeps a
   // square-root trial with its top bit set positive.
   logic signed [WORD_BITS:0] mul_a, mul_b;
   logic signed [2*WORD_BITS+1:0] prod;
   logic [4:0] pidx;
   logic [LW-1:0] bit_lo;
   logic [WORD_BITS-1:0] trial;
   always_comb begin
      pidx = {plane_ff, comp_ff};
      bit_lo = bit_ff - 1'b1;
      trial = root_ff | (WORD_BITS'(1) << bit_lo[LW-2:0]);
      mul_a = {pl_ff[pidx][WORD_BITS-1], pl_ff[pidx]};
      mul_b = mul_a;
      if (state_ff == fsc_pkg::ST_TEST)
         mul_b = {cen_ff[comp_ff][WORD_BITS-1], cen_ff[comp_ff]};
      if (state_ff == fsc_pkg::ST_SQRT) begin
         mul_a = {1'b0, trial};
         mul_b = {1'b0, trial};
      end
   end
   assign prod = mul_a * mul_b;
   logic [2*WORD_BITS-1:0] uprod;
   assign uprod = prod[2*WORD_BITS-1:0];

   logic neg_p;
   logic [WORD_BITS-1:0] mag_p;
   assign neg_p = pl_ff[pidx][WORD_BITS-1];
   assign mag_p = neg_p ? -pl_ff[pidx] : pl_ff[pidx];

   fsc_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .numer(mag_p), .denom(root_ff), .busy(div_busy), .quot(div_quot)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fsc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (in_op == fsc_pkg::OP_DERIVE) state_in = fsc_pkg::ST_SUM;
               else if (in_op == fsc_pkg::OP_TEST) state_in = fsc_pkg::ST_TEST;
            end
         end
         fsc_pkg::ST_SUM: if (comp_ff == 2'd3) state_in = fsc_pkg::ST_SQ;
         fsc_pkg::ST_SQ: if (comp_ff == 2'd2) state_in = fsc_pkg::ST_SQRT;
         fsc_pkg::ST_SQRT: begin
            if (bit_ff == '0) begin
               if (root_ff == '0 || (uprod <= acc_ff[2*WORD_BITS-1:0] && trial == '0))
                  state_in = fsc_pkg::ST_SUM;
               else state_in = fsc_pkg::ST_DIV;
               if (root_ff == '0 && plane_ff == 3'd5) state_in = fsc_pkg::ST_IDLE;
            end
         end
         fsc_pkg::ST_DIV: state_in = fsc_pkg::ST_DIV_WAIT;
         fsc_pkg::ST_DIV_WAIT: begin
            if (!div_busy) begin
               if (comp_ff != 2'd3) state_in = fsc_pkg::ST_DIV;
               else if (plane_ff == 3'd5) state_in = fsc_pkg::ST_IDLE;
               else state_in = fsc_pkg::ST_SUM;
            end
         end
         fsc_pkg::ST_TEST: if (comp_ff == 2'd2) state_in = fsc_pkg::ST_TEST_CHK;
         fsc_pkg::ST_TEST_CHK: if (plane_ff == 3'd5) state_in = fsc_pkg::ST_RESP;
            else state_in = fsc_pkg::ST_TEST;
         fsc_pkg::ST_RESP: if (rsp_tready) state_in = fsc_pkg::ST_IDLE;
         default: state_in = fsc_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_tready = (state_ff == fsc_pkg::ST_IDLE);
      rsp_tvalid = (state_ff == fsc_pkg::ST_RESP);
      rsp_tdata = {7'd0, inside_ff};
      div_start = (state_ff == fsc_pkg::ST_DIV);
   end

   logic signed [WORD_BITS:0] psum;
   logic [1:0] row;
   always_comb begin
      row = plane_ff[2:1];
      if (plane_ff[0])
         psum = mat_ff[{comp_ff, 2'd3}] - mat_ff[{comp_ff, row}];
      else
         psum = mat_ff[{comp_ff, 2'd3}] + mat_ff[{comp_ff, row}];
   end

   logic signed [WORD_BITS-1:0] qs;
   assign qs = neg_p ? -div_quot : ((div_quot[WORD_BITS-1]) ? WMAX : div_quot);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsc_pkg::ST_IDLE;
         for (int i = 0; i < 16; i++) mat_ff[i] <= '0;
         for (int i = 0; i < 24; i++) pl_ff[i] <= '0;
         plane_ff <= '0;
         comp_ff <= '0;
         inside_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            fsc_pkg::ST_IDLE: begin
               plane_ff <= '0;
               comp_ff <= '0;
               acc_ff <= '0;
               root_ff <= '0;
               if (req_tvalid) begin
                  if (in_op == fsc_pkg::OP_LOAD)
                     mat_ff[in_idx] <= sat_w(AW'(in_val));
                  cen_ff[0] <= sat_w(AW'(in_cx));
                  cen_ff[1] <= sat_w(AW'(in_cy));
                  cen_ff[2] <= sat_w(AW'(in_cz));
                  rad_ff <= sat_w(AW'($signed({1'b0, in_rad})));
                  inside_ff <= 1'b1;
               end
            end
            fsc_pkg::ST_SUM: begin
               pl_ff[pidx] <= sat_w(AW'(psum));
               comp_ff <= comp_ff + 1'b1;
               acc_ff <= '0;
               root_ff <= '0;
               bit_ff <= LW'(WORD_BITS);
            end
            fsc_pkg::ST_SQ: begin
               acc_ff <= acc_ff + AW'(prod);
               comp_ff <= (comp_ff == 2'd2) ? 2'd0 : comp_ff + 1'b1;
            end
            fsc_pkg::ST_SQRT: begin
               // bit_ff counts down from WORD_BITS; each step tries bit bit_ff-1.
               if (bit_ff != '0) begin
                  bit_ff <= bit_ff - 1'b1;
               end
               if (bit_ff == '0) begin
                  comp_ff <= '0;
                  if (root_ff == '0) plane_ff <= plane_ff + 1'b1;
               end
            end
            fsc_pkg::ST_DIV_WAIT: begin
               if (!div_busy) begin
                  pl_ff[pidx] <= qs;
                  comp_ff <= comp_ff + 1'b1;
                  if (comp_ff == 2'd3) plane_ff <= plane_ff + 1'b1;
               end
            end
            fsc_pkg::ST_TEST: begin
               if (comp_ff == 2'd0)
                  acc_ff <= ((AW'(pl_ff[{plane_ff, 2'd3}]) + AW'($signed({1'b0, rad_ff})))
                             <<< FRAC_BITS) + AW'(prod);
               else acc_ff <= acc_ff + AW'(prod);
               comp_ff <= (comp_ff == 2'd2) ? 2'd0 : comp_ff + 1'b1;
            end
            fsc_pkg::ST_TEST_CHK: begin
               if (acc_ff[AW-1]) inside_ff <= 1'b0;
               plane_ff <= plane_ff + 1'b1;
            end
            default: ;
         endcase
      end
      // Square-root trial step shares the multiplier with a shifted bit.
      if (state_ff == fsc_pkg::ST_SQRT && bit_ff != '0) begin
         if (uprod <= acc_ff[2*WORD_BITS-1:0]) root_ff <= trial;
      end
   end

`ifndef ASSERT_OFF
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("result and ready together");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy) else $error("divider restarted while busy");
`endif
endmodule

// File: verif/frustum_sphere_cull_unit_tb.sv
// Self-checking testbench of the frustum sphere cull unit: directed and random words.
`timescale 1ns / 100ps

module frustum_sphere_cull_unit_tb;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_WORDS = 1300;

   // Culling scoreboard: it keeps its own copy of the matrix and the planes,
   // predicts each sphere verdict and checks the verdicts in order.
   class cull_scoreboard;
      longint matrix_q[16];
      longint planes_q[24];
      bit verdicts_q[$];
      int errors;

      function new();
         foreach (matrix_q[i]) matrix_q[i] = 0;
         foreach (planes_q[i]) planes_q[i] = 0;
         errors = 0;
      endfunction

      function longint clamp_word(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // Floor of the square root of a wide unsigned value.
      function logic [127:0] root_floor(logic [127:0] x);
         logic [127:0] r;
         logic [127:0] t;
         r = 0;
         for (int b = 63; b >= 0; b--) begin
            t = r | (128'd1 << b);
            if (t * t <= x) r = t;
         end
         return r;
      endfunction

      // (p << 16) / len, truncated toward zero, saturated to the word.
      function longint scale_comp(longint p, logic [127:0] len);
         logic [127:0] n;
         logic [127:0] q;
         longint m;
         m = (p < 0) ? -p : p;
         n = 128'(m) << 16;
         q = n / len;
         if (p < 0) begin
            if (q > 128'h8000_0000) q = 128'h8000_0000;
            return -longint'(q[63:0]);
         end
         if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
         return longint'(q[63:0]);
      endfunction

      function void derive_planes();
         logic [127:0] sum;
         logic [127:0] len;
         longint a;
         longint b;
         int row;
         for (int k = 0; k < 6; k++) begin
            row = k / 2;
            sum = 0;
            for (int c = 0; c < 4; c++) begin
               a = matrix_q[4 * c + 3];
               b = matrix_q[4 * c + row];
               planes_q[4 * k + c] = clamp_word((k % 2) ? a - b : a + b);
            end
            for (int c = 0; c < 3; c++)
               sum = sum + 128'(planes_q[4 * k + c] * planes_q[4 * k + c]);
            len = root_floor(sum);
            // A plane with a zero-length normal keeps its raw components.
            if (len != 0)
               for (int c = 0; c < 4; c++)
                  planes_q[4 * k + c] = scale_comp(planes_q[4 * k + c], len);
         end
      endfunction

      function void note_input(logic [167:0] word);
         fsc_pkg::op_type op;
         longint cen[3];
         longint rad;
         logic signed [127:0] acc;
         logic signed [127:0] pw;
         logic signed [127:0] cw;
         bit verdict;
         op = fsc_pkg::op_type'(word[1:0]);
         case (op)
            fsc_pkg::OP_LOAD: matrix_q[word[5:2]] = longint'($signed(word[37:6]));
            fsc_pkg::OP_DERIVE: derive_planes();
            fsc_pkg::OP_TEST: begin
               cen[0] = longint'($signed(word[69:38]));
               cen[1] = longint'($signed(word[101:70]));
               cen[2] = longint'($signed(word[133:102]));
               rad = longint'(word[164:134]);
               verdict = 1'b1;
               for (int k = 0; k < 6; k++) begin
                  acc = planes_q[4 * k + 3] + rad;
                  acc = acc <<< 16;
                  for (int c = 0; c < 3; c++) begin
                     pw = planes_q[4 * k + c];
                     cw = cen[c];
                     acc = acc + pw * cw;
                  end
                  if (acc < 0) verdict = 1'b0;
               end
               verdicts_q.push_back(verdict);
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [7:0] word);
         bit want;
         if (verdicts_q.size() == 0) begin
            $error("unexpected result word 0x%02h", word);
            errors++;
            return;
         end
         want = verdicts_q.pop_front();
         if (word[0] !== want) begin
            $error("inside_res: expected %0d, got %0d", want, word[0]);
            errors++;
         end
      endfunction

      function int pending();
         return verdicts_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [167:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [7:0] rsp_tdata;

   cull_scoreboard board;
   int cycle_count;
   bit no_idle;
   int words_sent;

   frustum_sphere_cull_unit dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [167:0] pack_word(fsc_pkg::op_type op, logic [3:0] idx,
         logic [31:0] val, logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
         logic [30:0] rad);
      return {3'b000, rad, cz, cy, cx, val, idx, op};
   endfunction

   // Presents one word at a falling edge and holds it until it is taken.
   // It returns at a falling edge with the valid still high, so that the
   // next word can follow without a gap.
   task automatic send_word(logic [167:0] word);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = word;
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      board.note_input(word);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_load(logic [3:0] idx, logic [31:0] val);
      send_word(pack_word(fsc_pkg::OP_LOAD, idx, val, $urandom, $urandom, $urandom,
         31'($urandom)));
   endtask

   task automatic send_derive();
      send_word(pack_word(fsc_pkg::OP_DERIVE, 4'($urandom), $urandom, $urandom, $urandom,
         $urandom, 31'($urandom)));
   endtask

   task automatic send_test(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
         logic [30:0] rad);
      send_word(pack_word(fsc_pkg::OP_TEST, 4'($urandom), $urandom, cx, cy, cz, rad));
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   // Matrix element: mostly within a few units so that spheres fall on both
   // sides of the planes, sometimes any 32-bit value to push the sums into
   // saturation.
   function automatic logic [31:0] pick_elem();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
   endfunction

   function automatic logic [31:0] pick_coord();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
   endfunction

   function automatic logic [30:0] pick_radius();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 31'($urandom);
      if (roll == 1) return 31'd0;
      return 31'($urandom_range(0, 32'h0002_0000));
   endfunction

   // Receiver: random stalls, with calm stretches when no_idle is set.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int burst;
      board = new();
      words_sent = 0;
      no_idle = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. A test before any derive sees all-zero planes.
      send_test(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 31'd0);
      // An all-zero matrix gives zero-length normals that stay unnormalized.
      send_derive();
      send_test(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
      // Identity matrix: the unit cube frustum.
      for (int i = 0; i < 4; i++) send_load(4'(5 * i), 32'h0001_0000);
      send_derive();
      send_test(32'h0000_8000, 32'h0000_0000, 32'h0000_0000, 31'd0);
      send_test(32'h0003_0000, 32'h0000_0000, 32'h0000_0000, 31'h0001_0000);
      send_test(32'h0003_0000, 32'h0000_0000, 32'h0000_0000, 31'h0003_0000);
      send_test(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
      // Unused op value: no result, no state change.
      send_word(pack_word(fsc_pkg::OP_NONE, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
         32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
      // Extreme elements saturate the plane sums.
      send_load(4'd3, 32'h7FFF_FFFF);
      send_load(4'd0, 32'h7FFF_FFFF);
      send_load(4'd15, 32'h8000_0000);
      send_load(4'd14, 32'h7FFF_FFFF);
      send_derive();
      send_test(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd0);
      send_test(32'h8000_0000, 32'h0001_0000, 32'h8000_0000, 31'd1);

      // The sender holds off until every verdict is back.
      wait_drained();

      // Random part: mostly full matrix loads, a derive and a run of tests.
      while (words_sent < RANDOM_WORDS) begin
         burst = $urandom_range(0, 99);
         no_idle = ($urandom_range(0, 4) == 0);
         if (burst < 80) begin
            for (int i = 0; i < 16; i++) send_load(4'(i), pick_elem());
            send_derive();
            repeat ($urandom_range(10, 30))
               send_test(pick_coord(), pick_coord(), pick_coord(), pick_radius());
         end else if (burst < 90) begin
            repeat ($urandom_range(1, 4)) send_load(4'($urandom), pick_elem());
            send_derive();
            repeat ($urandom_range(3, 10))
               send_test(pick_coord(), pick_coord(), pick_coord(), pick_radius());
         end else begin
            // Noise: unused ops, stray loads and tests with raw fields.
            repeat ($urandom_range(2, 8)) begin
               case ($urandom_range(0, 2))
                  0: send_word(pack_word(fsc_pkg::OP_NONE, 4'($urandom), $urandom,
                        $urandom, $urandom, $urandom, 31'($urandom)));
                  1: send_load(4'($urandom), $urandom);
                  default: send_test($urandom, $urandom, $urandom, 31'($urandom));
               endcase
            end
         end
      end
      no_idle = 1'b0;

      wait_drained();
      repeat (100) @(posedge clock);
      if (board.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
